// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL file of the display scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-style concurrent check, sampled on the rising clock, off in reset
`define CPDS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication check: when ante holds, cons must hold in the next cycle
`define CPDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cpds_pkg.sv =====
// Package: types, constants and the digit encoder of the charlieplexed display scanner.
`default_nettype none

package cpds_pkg;

  // Command codes on the action field
  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_NUMBER  = 3'd1,
    ACT_CHARGE  = 3'd2,
    ACT_PERCENT = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_e;

  localparam int unsigned NumPins  = 5;
  localparam int unsigned ImgBits  = 18;
  localparam int unsigned DigBits  = 16;

  // Image bit positions of the icons
  localparam int unsigned BitCharge  = 16;
  localparam int unsigned BitPercent = 17;

  localparam logic [7:0] NumMax   = 8'd199;
  localparam logic [2:0] PhaseMin = 3'd1;
  localparam logic [2:0] PhaseMax = 3'd5;

  // Seven-segment font, bit 0 = a ... bit 6 = g
  localparam logic [6:0] DIGIT_FONT [0:9] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef logic [ImgBits-1:0] image_t;
  typedef logic [NumPins-1:0] pins_t;

  // Digit segments for a value 0..199 with leading zeros blanked
  function automatic logic [DigBits-1:0] number_segments(logic [7:0] num);
    logic [6:0]         rem;
    logic [14:0]        prod;
    logic [3:0]         tens;
    logic [6:0]         tens_x10;
    logic [3:0]         units;
    logic [DigBits-1:0] seg;
    rem      = (num >= 8'd100) ? 7'(num - 8'd100) : num[6:0];
    // rem / 10 by reciprocal, exact for rem below 100
    prod     = 15'(rem) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = 7'({3'b000, tens}) * 7'd10;
    units    = 4'(rem - tens_x10);
    seg      = '0;
    seg[6:0] = DIGIT_FONT[units];
    if (num >= 8'd10) begin
      seg[13:7] = DIGIT_FONT[tens];
    end
    if (num >= 8'd100) begin
      seg[15:14] = 2'b11;
    end
    return seg;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cpds_if.sv =====
// Valid/ready channel interfaces: command beats in, pin pattern beats out.
`default_nettype none

interface cpds_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface cpds_pin_if;
  logic       valid;
  logic       ready;
  logic [4:0] pin_drive;
  logic [4:0] pin_level;
  logic [2:0] scan_phase;

  modport source (output valid, output pin_drive, output pin_level, output scan_phase,
                  input ready);
  modport sink   (input valid, input pin_drive, input pin_level, input scan_phase,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/charlieplex_digit_display_scan.sv =====
// Charlieplexed 18-segment display scanner: command register, image/phase state, pin register.
//
// Channels: cmd_i takes command beats (action, value); pin_o delivers one pin pattern
// beat for every scan tick. Both are valid/ready; a beat moves when both are high.
// Set-number, icon and clear commands update the segment image and give no beat.
// Commands 5..7 and numbers above 199 are dropped without effect.
//
// Path: a command is captured in an input register and decoded against the segment
// image and scan phase when it leaves that register; a tick's pattern is then loaded
// into the output register, which drives pin_o.valid.
// Throughput: one command per cycle, sustained while pin_o.ready is high. The single
// output register is the only pattern buffer, so a stalled receiver holds the pattern there;
// the input register still takes one more beat, and a non-tick command keeps flowing
// since it needs no output slot.
//
// Reset (asynchronous, active low): image cleared, scan phase 1, both registers empty.
`default_nettype none

`include "assert_macros.svh"

module charlieplex_digit_display_scan
  import cpds_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  cpds_cmd_if.sink        cmd_i,
  cpds_pin_if.source      pin_o
);

  // Input register
  logic       in_valid_q;
  logic [2:0] in_action_q;
  logic [7:0] in_value_q;

  // State
  image_t     image_q, image_d;
  logic [2:0] phase_q, phase_d;

  // Output register
  logic       out_valid_q;
  pins_t      out_drive_q, out_drive_d;
  pins_t      out_level_q, out_level_d;
  logic [2:0] out_phase_q;

  logic       in_tick;
  logic       out_free;
  logic       in_go;
  logic [2:0] eff_phase;

  // Terms used by the checks
  logic       tick_go;
  logic       clear_go;
  logic       phase_ok;
  logic       level_ok;

  // Stage handshake
  assign in_tick     = (in_action_q == ACT_TICK);
  assign out_free    = !out_valid_q || pin_o.ready;
  assign in_go       = in_valid_q && (!in_tick || out_free);
  assign cmd_i.ready = !in_valid_q || in_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      in_action_q <= cmd_i.action;
      in_value_q  <= cmd_i.value;
    end
  end

  // Out-of-range phase scans as phase 1
  assign eff_phase = (phase_q < PhaseMin || phase_q > PhaseMax) ? PhaseMin : phase_q;

  // Image and phase update
  always_comb begin
    image_d = image_q;
    phase_d = phase_q;
    if (in_go) begin
      case (in_action_q)
        ACT_TICK: begin
          phase_d = (eff_phase >= PhaseMax) ? PhaseMin : 3'(eff_phase + 3'd1);
        end
        ACT_NUMBER: begin
          if (in_value_q <= NumMax) begin
            image_d[DigBits-1:0] = number_segments(in_value_q);
          end
        end
        ACT_CHARGE: begin
          image_d[BitCharge] = (in_value_q != 8'd0);
        end
        ACT_PERCENT: begin
          image_d[BitPercent] = (in_value_q != 8'd0);
        end
        ACT_CLEAR: begin
          image_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_q <= '0;
      phase_q <= PhaseMin;
    end else begin
      image_q <= image_d;
      phase_q <= phase_d;
    end
  end

  // Pin pattern: phase pin high, mapped lit segments pull their pins low
  always_comb begin
    out_level_d = '0;
    case (eff_phase)
      3'd2: begin
        out_level_d    = 5'b00010;
        out_drive_d    = out_level_d;
        out_drive_d[0] = image_q[1];
        out_drive_d[2] = image_q[7];
        out_drive_d[3] = image_q[15];
        out_drive_d[4] = image_q[BitPercent];
      end
      3'd3: begin
        out_level_d    = 5'b00100;
        out_drive_d    = out_level_d;
        out_drive_d[0] = image_q[3];
        out_drive_d[1] = image_q[8];
        out_drive_d[3] = image_q[14];
        out_drive_d[4] = image_q[BitCharge];
      end
      3'd4: begin
        out_level_d    = 5'b01000;
        out_drive_d    = out_level_d;
        out_drive_d[0] = image_q[5];
        out_drive_d[1] = image_q[10];
        out_drive_d[2] = image_q[9];
      end
      3'd5: begin
        out_level_d    = 5'b10000;
        out_drive_d    = out_level_d;
        out_drive_d[0] = image_q[6];
        out_drive_d[1] = image_q[11];
        out_drive_d[2] = image_q[12];
        out_drive_d[3] = image_q[13];
      end
      default: begin
        out_level_d    = 5'b00001;
        out_drive_d    = out_level_d;
        out_drive_d[1] = image_q[0];
        out_drive_d[2] = image_q[2];
        out_drive_d[3] = image_q[4];
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_go && in_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go && in_tick) begin
      out_drive_q <= out_drive_d;
      out_level_q <= out_level_d;
      out_phase_q <= eff_phase;
    end
  end

  assign pin_o.valid      = out_valid_q;
  assign pin_o.pin_drive  = out_drive_q;
  assign pin_o.pin_level  = out_level_q;
  assign pin_o.scan_phase = out_phase_q;

  // Checks
  assign tick_go  = in_go && in_tick;
  assign clear_go = in_go && (in_action_q == ACT_CLEAR);
  assign phase_ok = (phase_q >= PhaseMin) && (phase_q <= PhaseMax);
  assign level_ok = !out_valid_q ||
                    ($onehot(out_level_q) && ((out_level_q & ~out_drive_q) == 5'd0));

  `CPDS_ASSERT(a_phase_range, clk_i, rst_ni, phase_ok, "scan phase left 1..5")
  `CPDS_ASSERT(a_level_onehot, clk_i, rst_ni, level_ok, "high pin not single or not driven")
  `CPDS_ASSERT_NEXT(a_tick_advance, clk_i, rst_ni, tick_go, phase_q != $past(phase_q), "phase held")
  `CPDS_ASSERT_NEXT(a_clear_blank, clk_i, rst_ni, clear_go, image_q == '0, "segments still lit")

endmodule

`default_nettype wire
